FILE: design/bitmap_frame_allocator_defines.svh
// Assertion macros for the bitmap frame allocator
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bfa_pkg.sv
// Shared types and opcode constants for the bitmap frame allocator
`default_nettype none
package bfa_pkg;

  typedef logic [2:0] op_t;

  localparam op_t OP_INIT    = 3'd0;
  localparam op_t OP_ALLOC   = 3'd1;
  localparam op_t OP_FREE    = 3'd2;
  localparam op_t OP_RELEASE = 3'd3;
  localparam op_t OP_RESERVE = 3'd4;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned CNT16_W = 16;
  localparam int unsigned IN_W    = 72;
  localparam int unsigned OUT_W   = 72;

endpackage
`default_nettype wire

FILE: design/bitmap_frame_allocator.sv
// First-fit bitmap frame allocator: bitmap in a 1R1W memory, one word per cycle
// Reset: a fill pass over all MAP_WORDS words fills the map with ones; no input taken meanwhile.
// Alloc: a first-fit scan over the words below the limit, then marking of the run's words.
// Free, release, reserve: a read-modify-write of each word touched; region ops then set block 0.
// Init: a fill pass over all MAP_WORDS words. One item at a time; the map memory port sets the pace.
// Results wait in an output register while the next word is taken.
`default_nettype none
module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS  = 32768,
  parameter int unsigned BLOCK_BYTES = 4096,
  parameter int unsigned WORD_BITS   = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [15:0]      cfg_wdata,   // block_limit
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,    // op[2:0], base_address[34:3], length[66:35]
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata    // address[31:0], success[32],
                                             // free_blocks[48:33], used_blocks[64:49]
);

  localparam int unsigned MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned WSH = $clog2(WORD_BITS);
  localparam int unsigned BSH = $clog2(BLOCK_BYTES);
  localparam int unsigned CW  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned BW  = AW + WSH + 1;
  localparam int unsigned LW  = (CW > 16) ? CW : 16;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILL  = 4'd1;
  localparam logic [3:0] S_SET   = 4'd2;
  localparam logic [3:0] S_CNT   = 4'd3;
  localparam logic [3:0] S_RUN   = 4'd4;
  localparam logic [3:0] S_DRAIN = 4'd5;
  localparam logic [3:0] S_FIXR  = 4'd6;
  localparam logic [3:0] S_FIXW  = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]           state_r;
  logic [15:0]          limit_r;
  logic [CW-1:0]        used_r;
  op_t                  op_r;
  logic [ADDR_W-1:0]    base_r;
  logic [LEN_W-1:0]     len_in_r;
  logic [AW-1:0]        fill_ptr_r;
  logic                 fill_ret_r;
  logic [BW-1:0]        s_r, e_r, n_r, len_r;
  logic                 v_r, fix_r;
  logic [AW-1:0]        wp_r, wlast_r, pa_r;
  logic                 pv_r;
  logic [AW:0]          sp_r, nw_r;
  logic [BW:0]          run_r;
  logic [ADDR_W-1:0]    addr_r;
  logic                 ok_r;
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_data_r;

  logic [CW-1:0]        lim_c, free_c;
  logic [BW-1:0]        limb;

  // map memory
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [WORD_BITS-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  assign lim_c  = (LW'(limit_r) < LW'(NUM_BLOCKS)) ? CW'(limit_r) : CW'(NUM_BLOCKS);
  assign limb   = BW'(lim_c);
  assign free_c = (used_r < lim_c) ? (lim_c - used_r) : '0;

  // mask of blocks in [s_r, e_r) within word pa_r
  logic [WORD_BITS-1:0] run_mask;
  always_comb begin
    logic [BW-1:0] blk;
    for (int j = 0; j < WORD_BITS; j++) begin
      blk = {1'b0, pa_r, WSH'(j)};
      run_mask[j] = (blk >= s_r) && (blk < e_r);
    end
  end

  // scan of one word: first position where the free run reaches len_r
  logic             sc_found;
  logic [WSH-1:0]   sc_j;
  logic [BW:0]      sc_run_nxt;
  always_comb begin
    logic [BW-1:0]  blk;
    logic           hit;
    logic [WSH-1:0] lu;
    logic [BW:0]    runj;
    logic           ub;
    hit = 1'b0;
    lu = '0;
    runj = '0;
    sc_found = 1'b0;
    sc_j = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      blk = {1'b0, pa_r, WSH'(j)};
      ub = rd_q[j] | (blk >= limb);
      if (ub) begin
        hit = 1'b1;
        lu = WSH'(j);
      end else begin
        runj = hit ? ((BW+1)'(j) - (BW+1)'(lu)) : (run_r + (BW+1)'(j) + (BW+1)'(1));
        if (!sc_found && runj >= (BW+1)'(len_r)) begin
          sc_found = 1'b1;
          sc_j = WSH'(j);
        end
      end
    end
    sc_run_nxt = hit ? ((BW+1)'(WORD_BITS - 1) - (BW+1)'(lu))
                     : (run_r + (BW+1)'(WORD_BITS));
  end

  // memory control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pa_r;
    mem_wd = v_r ? (rd_q | run_mask) : (rd_q & ~run_mask);
    mem_ra = wp_r;
    case (state_r)
      S_FILL: begin
        mem_we = 1'b1;
        mem_wa = fill_ptr_r;
        mem_wd = '1;
      end
      S_RUN, S_DRAIN: begin
        mem_we = pv_r;
      end
      S_FIXR: begin
        mem_ra = '0;
      end
      S_FIXW: begin
        mem_we = 1'b1;
        mem_wa = '0;
        mem_wd = rd_q | WORD_BITS'(1);
      end
      S_SCAN: begin
        mem_ra = AW'(sp_r);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  // setup arithmetic for range ops
  logic [32:0] first33, nreq33, lim33, room33, ncl33;
  assign first33 = 33'(base_r >> BSH);
  assign nreq33  = (op_r == OP_FREE) ? 33'(len_in_r) : (33'(len_in_r >> BSH) + 33'd1);
  assign lim33   = 33'(lim_c);
  assign room33  = lim33 - first33;
  assign ncl33   = (first33 >= lim33) ? 33'd0 : ((nreq33 > room33) ? room33 : nreq33);

  logic [BW:0]   cnt_sum;
  logic [CW-1:0] cnt_new;
  assign cnt_sum = (BW+1)'(used_r) + (BW+1)'(n_r);
  always_comb begin
    if (v_r) begin
      cnt_new = (cnt_sum > (BW+1)'(lim_c)) ? lim_c : CW'(cnt_sum);
    end else begin
      cnt_new = (n_r >= BW'(used_r)) ? '0 : CW'(BW'(used_r) - n_r);
    end
  end

  logic [BW-1:0] alloc_start;
  assign alloc_start = {1'b0, pa_r, sc_j} + BW'(1) - len_r;

  logic done_load;
  assign done_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_FILL;
      fill_ptr_r <= '0;
      fill_ret_r <= 1'b0;
      limit_r    <= 16'd32768;
      used_r     <= CW'(NUM_BLOCKS);
      pv_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r     <= in_tdata[2:0];
            base_r   <= in_tdata[34:3];
            len_in_r <= in_tdata[66:35];
            addr_r   <= '0;
            ok_r     <= 1'b1;
            pv_r     <= 1'b0;
            state_r  <= S_SET;
          end
        end
        S_FILL: begin
          fill_ptr_r <= fill_ptr_r + AW'(1);
          if (fill_ptr_r == AW'(MAP_WORDS - 1)) begin
            fill_ptr_r <= '0;
            state_r    <= fill_ret_r ? S_DONE : S_IDLE;
          end
        end
        S_SET: begin
          fix_r <= (op_r == OP_RELEASE) || (op_r == OP_RESERVE);
          v_r   <= (op_r == OP_RESERVE) || (op_r == OP_ALLOC);
          s_r   <= BW'(first33);
          n_r   <= BW'(ncl33);
          case (op_r)
            OP_INIT: begin
              used_r     <= lim_c;
              fill_ret_r <= 1'b1;
              state_r    <= S_FILL;
            end
            OP_ALLOC: begin
              ok_r <= 1'b0;
              fix_r <= 1'b0;
              if (len_in_r != '0 && 33'(free_c) >= 33'(len_in_r)) begin
                len_r   <= BW'(len_in_r);
                sp_r    <= '0;
                run_r   <= '0;
                nw_r    <= (AW+1)'(((BW+1)'(limb) + (BW+1)'(WORD_BITS - 1)) >> WSH);
                state_r <= S_SCAN;
              end else begin
                state_r <= S_DONE;
              end
            end
            OP_FREE, OP_RELEASE, OP_RESERVE: begin
              state_r <= S_CNT;
            end
            default: begin
              ok_r    <= 1'b0;
              state_r <= S_DONE;
            end
          endcase
        end
        S_CNT: begin
          used_r  <= cnt_new;
          e_r     <= s_r + n_r;
          wp_r    <= AW'(s_r >> WSH);
          wlast_r <= AW'((s_r + n_r - BW'(1)) >> WSH);
          pv_r    <= 1'b0;
          if (n_r != '0) begin
            state_r <= S_RUN;
          end else if (fix_r && lim_c != '0) begin
            state_r <= S_FIXR;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_RUN: begin
          // read word wp_r while writing back the word read last cycle
          pv_r <= 1'b1;
          pa_r <= wp_r;
          if (wp_r == wlast_r) begin
            state_r <= S_DRAIN;
          end else begin
            wp_r <= wp_r + AW'(1);
          end
        end
        S_DRAIN: begin
          pv_r    <= 1'b0;
          state_r <= (fix_r && lim_c != '0) ? S_FIXR : S_DONE;
        end
        S_FIXR: begin
          state_r <= S_FIXW;
        end
        S_FIXW: begin
          state_r <= S_DONE;
        end
        S_SCAN: begin
          if (sp_r < nw_r) begin
            pv_r <= 1'b1;
            pa_r <= AW'(sp_r);
            sp_r <= sp_r + (AW+1)'(1);
          end else begin
            pv_r <= 1'b0;
          end
          if (pv_r) begin
            run_r <= sc_run_nxt;
            if (sc_found) begin
              ok_r    <= 1'b1;
              s_r     <= alloc_start;
              n_r     <= len_r;
              addr_r  <= ADDR_W'({alloc_start, {BSH{1'b0}}});
              pv_r    <= 1'b0;
              state_r <= S_CNT;
            end else if ((AW+1)'(pa_r) == nw_r - (AW+1)'(1)) begin
              pv_r    <= 1'b0;
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (done_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      out_data_r <= {7'd0, CNT16_W'(used_r), CNT16_W'(free_c), ok_r, addr_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `include "bitmap_frame_allocator_defines.svh"

  `BFA_ASSERT_NOW(a_used_bound, 1'b1, used_r <= CW'(NUM_BLOCKS), "used count above block total")
  `BFA_ASSERT_NOW(a_idle_no_write, state_r == S_IDLE, !mem_we, "map write while idle")
  `BFA_ASSERT_NOW(a_rmw_apart, state_r == S_RUN && mem_we, mem_wa != mem_ra, "RMW overlap")
  `BFA_ASSERT_NEXT(a_done_out, done_load, out_tvalid, "result lost at completion")

endmodule
`default_nettype wire

FILE: tb/bitmap_frame_allocator_tb.sv
// Self-checking testbench for the first-fit bitmap frame allocator
`default_nettype none
module bitmap_frame_allocator_tb;
  import bfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBLK     = 32768;
  localparam int unsigned BLK_SZ   = 4096;
  localparam op_t         OP_BAD_A = 3'd5;
  localparam op_t         OP_BAD_B = 3'd7;
  localparam int          DRAIN    = 1200;

  typedef struct packed {
    logic [31:0] addr;
    logic        ok;
    logic [15:0] free_cnt;
    logic [15:0] used_cnt;
  } alloc_res_t;

  typedef struct {
    op_t         op;
    logic [31:0] base;
    logic [31:0] len;
    bit          typed;
    alloc_res_t  res;
  } stim_row_t;

  logic clk, rst_n, cfg_we, in_tvalid, out_tready;
  logic [15:0] cfg_wdata;
  logic [IN_W-1:0] in_tdata;
  logic in_tready, out_tvalid;
  logic [OUT_W-1:0] out_tdata;

  bitmap_frame_allocator DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // shadow allocator state
  bit          frame_map [NBLK];
  int unsigned used_shadow;
  logic [15:0] limit_shadow;

  alloc_res_t  alloc_expq [$];
  int          accepted_cnt = 0;
  int          fail_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          typed_pending = 0;
  alloc_res_t  typed_res;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got, exp);
    $display("MISMATCH %s: got %0h expected %0h", what, got, exp);
    fail_cnt++;
  endtask

  function automatic int unsigned lim_now();
    return (limit_shadow < NBLK) ? limit_shadow : NBLK;
  endfunction

  function automatic longint unsigned mark_run(longint unsigned first, longint unsigned n,
                                               bit v);
    longint unsigned lim = lim_now();
    if (first >= lim) return 0;
    if (n > lim - first) n = lim - first;
    for (longint unsigned k = 0; k < n; k++) frame_map[first + k] = v;
    return n;
  endfunction

  function automatic void count_up(longint unsigned n);
    longint unsigned v = longint'(used_shadow) + n;
    used_shadow = (v > lim_now()) ? lim_now() : int'(v);
  endfunction

  function automatic void count_down(longint unsigned n);
    used_shadow = (n >= used_shadow) ? 0 : int'(longint'(used_shadow) - n);
  endfunction

  function automatic alloc_res_t predict_alloc(op_t op, logic [31:0] base, logic [31:0] len);
    alloc_res_t r;
    longint unsigned first = base / BLK_SZ;
    longint unsigned n, run, start;
    int unsigned lim = lim_now();
    int unsigned fr;
    r = '0;
    case (op)
      OP_INIT: begin
        foreach (frame_map[i]) frame_map[i] = 1'b1;
        used_shadow = lim;
        r.ok = 1'b1;
      end
      OP_ALLOC: begin
        fr = (used_shadow < lim) ? lim - used_shadow : 0;
        if (len != 0 && longint'(fr) >= longint'(len)) begin
          run = 0;
          for (int unsigned i = 0; i < lim; i++) begin
            if (frame_map[i]) run = 0;
            else begin
              run++;
              if (run == len) begin
                start = longint'(i) + 1 - len;
                void'(mark_run(start, len, 1'b1));
                count_up(len);
                r.addr = 32'(start * BLK_SZ);
                r.ok = 1'b1;
                break;
              end
            end
          end
        end
      end
      OP_FREE: begin
        count_down(mark_run(first, len, 1'b0));
        r.ok = 1'b1;
      end
      OP_RELEASE, OP_RESERVE: begin
        n = mark_run(first, len / BLK_SZ + 1, op == OP_RESERVE);
        if (op == OP_RESERVE) count_up(n);
        else count_down(n);
        if (lim > 0) frame_map[0] = 1'b1;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    lim = lim_now();
    r.free_cnt = 16'((used_shadow < lim) ? lim - used_shadow : 0);
    r.used_cnt = 16'(used_shadow);
    return r;
  endfunction

  // accept/compare on the rising edge
  always @(posedge clk) begin
    alloc_res_t got, exp, pred;
    if (rst_n && in_tvalid && in_tready) begin
      pred = predict_alloc(op_t'(in_tdata[2:0]), in_tdata[34:3], in_tdata[66:35]);
      alloc_expq.push_back(typed_pending ? typed_res : pred);
      accepted_cnt++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[31:0], out_tdata[32], out_tdata[48:33], out_tdata[64:49]};
      if (alloc_expq.size() == 0) begin
        report_mismatch("unexpected result word", out_tdata[31:0], '0);
      end else begin
        exp = alloc_expq.pop_front();
        if (got.addr !== exp.addr) report_mismatch("address", got.addr, exp.addr);
        if (got.ok !== exp.ok) report_mismatch("success", got.ok, exp.ok);
        if (got.free_cnt !== exp.free_cnt)
          report_mismatch("free_blocks", got.free_cnt, exp.free_cnt);
        if (got.used_cnt !== exp.used_cnt)
          report_mismatch("used_blocks", got.used_cnt, exp.used_cnt);
      end
    end
  end

  always @(negedge clk)
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

  task automatic send_word(input op_t op, input logic [31:0] base, len);
    int seen;
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tdata = {5'b0, len, base, op};
    seen = accepted_cnt;
    do @(negedge clk); while (accepted_cnt == seen);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (alloc_expq.size() != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    wait_drained();
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    limit_shadow = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_random();
    int unsigned lim = lim_now();
    int unsigned r = $urandom_range(99);
    op_t op;
    logic [31:0] base, len;
    if (r < 4) op = OP_INIT;
    else if (r < 40) op = OP_ALLOC;
    else if (r < 58) op = OP_FREE;
    else if (r < 78) op = OP_RELEASE;
    else if (r < 93) op = OP_RESERVE;
    else op = op_t'($urandom_range(5, 7));
    base = ($urandom_range(9) == 0) ? $urandom
         : $urandom_range(0, lim + 2) * BLK_SZ + $urandom_range(0, BLK_SZ - 1);
    r = $urandom_range(99);
    if (op == OP_ALLOC)
      len = (r < 85) ? $urandom_range(1, 8) : (r < 90) ? 0
          : (r < 95) ? $urandom_range(1, lim + 1) : $urandom;
    else if (op == OP_FREE)
      len = (r < 92) ? $urandom_range(0, 16) : $urandom;
    else
      len = (r < 92) ? $urandom_range(0, 16) * BLK_SZ + $urandom_range(0, BLK_SZ - 1)
          : $urandom;
    send_word(op, base, len);
  endtask

  stim_row_t dir_rows [20] = '{
    '{OP_INIT,    32'h0,        32'h0,        1, '{32'h0,    1'b1, 16'd0,     16'd32768}},
    '{OP_BAD_B,   32'hFFFFFFFF, 32'hFFFFFFFF, 1, '{32'h0,    1'b0, 16'd0,     16'd32768}},
    '{OP_ALLOC,   32'h0,        32'h1,        1, '{32'h0,    1'b0, 16'd0,     16'd32768}},
    '{OP_RELEASE, 32'h0,        32'hFFFFFFFF, 1, '{32'h0,    1'b1, 16'd32768, 16'd0}},
    '{OP_ALLOC,   32'h0,        32'h0,        1, '{32'h0,    1'b0, 16'd32768, 16'd0}},
    '{OP_ALLOC,   32'h0,        32'h1,        1, '{32'h1000, 1'b1, 16'd32767, 16'd1}},
    '{OP_ALLOC,   32'h0,        32'hFFFFFFFF, 1, '{32'h0,    1'b0, 16'd32767, 16'd1}},
    '{OP_ALLOC,   32'h0,        32'd100,      0, '0},
    '{OP_FREE,    32'hFFFFFFFF, 32'hFFFFFFFF, 0, '0},
    '{OP_FREE,    32'h1000,     32'h1,        0, '0},
    '{OP_RESERVE, 32'h0,        32'h0,        0, '0},
    '{OP_RESERVE, 32'h07FFF000, 32'hFFF,      0, '0},
    '{OP_RELEASE, 32'h10000,    32'h8000,     0, '0},
    '{OP_ALLOC,   32'h0,        32'd32000,    0, '0},
    '{OP_BAD_A,   32'h12345678, 32'h9ABCDEF0, 0, '0},
    '{OP_FREE,    32'h0,        32'hFFFFFFFF, 0, '0},
    '{OP_ALLOC,   32'h0,        32'd32768,    0, '0},
    '{OP_ALLOC,   32'h0,        32'h1,        0, '0},
    '{OP_RESERVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, '0},
    '{OP_INIT,    32'h0,        32'h0,        0, '0}
  };

  logic [15:0] phase_limit [8] = '{16'd64, 16'd0, 16'd65535, 16'd1000, 16'd33,
                                   16'd300, 16'd32768, 16'd100};

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    foreach (frame_map[i]) frame_map[i] = 1'b1;
    used_shadow = NBLK;
    limit_shadow = 16'd32768;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      typed_pending = dir_rows[i].typed;
      typed_res = dir_rows[i].res;
      send_word(dir_rows[i].op, dir_rows[i].base, dir_rows[i].len);
    end
    typed_pending = 1'b0;

    foreach (phase_limit[p]) begin
      write_limit(phase_limit[p]);
      // idle pattern rotates: none, sender, receiver, both
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      // start each phase with a few region releases so allocs have room
      repeat (3) send_word(OP_RELEASE, $urandom_range(0, 8) * BLK_SZ,
                           $urandom_range(0, 40) * BLK_SZ);
      for (int k = 0; k < 67; k++) begin
        if (p == 2 && k == 35) wait_drained();
        send_random();
      end
    end

    wait_drained();
    repeat (DRAIN) @(negedge clk);
    if (alloc_expq.size() != 0)
      report_mismatch("results never arrived", 32'(alloc_expq.size()), '0);
    if (fail_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+design
design/bfa_pkg.sv
design/bitmap_frame_allocator.sv
tb/bitmap_frame_allocator_tb.sv
